@@ hdl/cma_pkg.sv @@
// Shared types, codes and calendar tables for the cron minute alarm.
`timescale 1ns / 1ps

package cma_pkg;

  // Largest year the calendar may hold.
  localparam logic [13:0] MAX_YEAR = 14'd9999;

  // Opcodes of an input item.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MINUTE_MASK  = 3'd0;
  localparam logic [2:0] CFG_HOUR_MASK    = 3'd1;
  localparam logic [2:0] CFG_DAY_MASK     = 3'd2;
  localparam logic [2:0] CFG_MONTH_MASK   = 3'd3;
  localparam logic [2:0] CFG_WEEKDAY_MASK = 3'd4;
  localparam logic [2:0] CFG_DAY_WILD     = 3'd5;
  localparam logic [2:0] CFG_WEEKDAY_WILD = 3'd6;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LOAD = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic        opcode;
    logic [13:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
    logic [4:0]  load_hour;
    logic [5:0]  load_minute;
  } item_t;

  typedef struct packed {
    logic [13:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [2:0]  weekday;
    logic        alarm;
    status_e     status;
  } result_t;

  typedef struct packed {
    logic [59:0] minute_mask;
    logic [23:0] hour_mask;
    logic [30:0] day_mask;
    logic [11:0] month_mask;
    logic [7:0]  weekday_mask;
    logic        day_wild;
    logic        weekday_wild;
  } cfg_t;

  // Registered input item with the decoded load date.
  typedef struct packed {
    logic        opcode;
    logic        load_ok;
    logic [13:0] year;
    logic [6:0]  cent;    // year / 100
    logic [6:0]  yrem;    // year % 100
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [13:0] wk_year; // year of the weekday formula (previous year in Jan and Feb)
    logic [7:0]  wk_cent; // wk_year / 100
  } prep_t;

  // Calendar state after one step.
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [2:0]  wday;
  } date_t;

  // Days in a month; zero for a month code that is not a month.
  function automatic logic [4:0] month_len(logic [3:0] month, logic leap);
    logic [4:0] len;
    case (month) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Month term of the weekday formula.
  function automatic logic [2:0] month_offset(logic [3:0] month);
    logic [2:0] off;
    case (month)
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

endpackage

@@ hdl/cma_if.sv @@
// Handshake channels of the cron minute alarm: input items, results and configuration.
`timescale 1ns / 1ps

interface cma_item_if;
  logic          valid;
  logic          ready;
  cma_pkg::item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface cma_result_if;
  logic             valid;
  logic             ready;
  cma_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface cma_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [59:0] wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

@@ hdl/cron_minute_alarm.sv @@
// Top level of the cron minute alarm: handshake, configuration registers and result register.
`timescale 1ns / 1ps
// Flow: an accepted item waits in the input register and moves into the result register once
// that register is free or its result is being taken; the new result is valid from then on.
// Throughput: one item per cycle unless results back up; the calendar update, the weekday
// of a loaded date and the mask match fit between the input register and the result register.
// Reset: the clock holds 00:00 on 1 January of year 1 (a Monday), all masks are cleared and
// both wildcard bits are set; no clearing pass is needed, items are taken at once.

module cron_minute_alarm (
  input  logic               clk_i,
  input  logic               rst_ni,
  cma_item_if.sink           in_ch,
  cma_result_if.source       res_ch,
  cma_cfg_if.sink            cfg_ch
);

  // Configuration registers. Write only while no item is in flight; this is not enforced.
  cma_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.minute_mask  <= '0;
      cfg_q.hour_mask    <= '0;
      cfg_q.day_mask     <= '0;
      cfg_q.month_mask   <= '0;
      cfg_q.weekday_mask <= '0;
      cfg_q.day_wild     <= 1'b1;
      cfg_q.weekday_wild <= 1'b1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        cma_pkg::CFG_MINUTE_MASK:  cfg_q.minute_mask  <= cfg_ch.wdata;
        cma_pkg::CFG_HOUR_MASK:    cfg_q.hour_mask    <= cfg_ch.wdata[23:0];
        cma_pkg::CFG_DAY_MASK:     cfg_q.day_mask     <= cfg_ch.wdata[30:0];
        cma_pkg::CFG_MONTH_MASK:   cfg_q.month_mask   <= cfg_ch.wdata[11:0];
        cma_pkg::CFG_WEEKDAY_MASK: cfg_q.weekday_mask <= cfg_ch.wdata[7:0];
        cma_pkg::CFG_DAY_WILD:     cfg_q.day_wild     <= cfg_ch.wdata[0];
        cma_pkg::CFG_WEEKDAY_WILD: cfg_q.weekday_wild <= cfg_ch.wdata[0];
        default: ; // Addresses past the register list are ignored.
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // Two-stage flow: the input register holds an accepted item, the result register holds
  // its answer. The input register drains whenever the result register is free or being
  // taken, so a new item enters while a finished result waits.
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic in_fire;
  logic adv;

  assign adv         = s1_valid_q && (!out_valid_q || res_ch.ready);
  assign in_ch.ready = !s1_valid_q || adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (res_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register with load-date checking.
  cma_pkg::prep_t prep;

  cma_front u_front (
    .clk_i  (clk_i),
    .load_i (in_fire),
    .item_i (in_ch.payload),
    .prep_o (prep)
  );

  // Calendar state; it commits when the item moves into the result register.
  cma_pkg::date_t   now;
  cma_pkg::status_e status;

  cma_calendar u_calendar (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .prep_i   (prep),
    .now_o    (now),
    .status_o (status)
  );

  // Cron match of the time after the step.
  logic alarm;

  cma_match u_match (
    .cfg_i   (cfg_q),
    .now_i   (now),
    .alarm_o (alarm)
  );

  // Result register.
  cma_pkg::result_t res_q, res_d;

  always_comb begin
    res_d.cur_year   = now.year;
    res_d.cur_month  = now.month;
    res_d.cur_day    = now.day;
    res_d.cur_hour   = now.hour;
    res_d.cur_minute = now.minute;
    res_d.weekday    = now.wday;
    res_d.alarm      = alarm;
    res_d.status     = status;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign res_ch.valid   = out_valid_q;
  assign res_ch.payload = res_q;

`ifndef SYNTHESIS
  // An item that leaves the input register shows up as a result on the next cycle.
  a_adv_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("cron_minute_alarm: stepped item did not reach the result register");

  // An overflow is reported only while holding the last minute of the last year.
  a_overflow_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.status == cma_pkg::ST_OVERFLOW) |->
      (res_q.cur_year == cma_pkg::MAX_YEAR) && (res_q.cur_month == 4'd12) &&
      (res_q.cur_day == 5'd31) && (res_q.cur_hour == 5'd23) && (res_q.cur_minute == 6'd59))
    else $error("cron_minute_alarm: overflow reported away from the last minute");

  // A result always carries a weekday from Sunday to Saturday.
  a_weekday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.weekday != 3'd7))
    else $error("cron_minute_alarm: weekday out of range");
`endif

endmodule

@@ hdl/cma_front.sv @@
// Input register stage: checks a load date and splits its year by 100.
`timescale 1ns / 1ps

module cma_front (
  input  logic             clk_i,
  input  logic             load_i,
  input  cma_pkg::item_t   item_i,
  output cma_pkg::prep_t   prep_o
);

  cma_pkg::prep_t prep_d;
  cma_pkg::prep_t prep_q;
  logic [26:0]    prod;
  logic [7:0]     quo;
  logic [13:0]    hundreds;
  logic [13:0]    rem_full;
  logic [6:0]     rem;
  logic           leap;
  logic           early;
  logic [4:0]     mlen;

  // year / 100 by reciprocal: exact for every 14-bit year.
  assign prod     = {13'd0, item_i.load_year} * 27'd5243;
  assign quo      = prod[26:19];
  assign hundreds = {quo, 6'd0} + {1'b0, quo, 5'd0} + {4'd0, quo, 2'd0};
  assign rem_full = item_i.load_year - hundreds;
  assign rem      = rem_full[6:0];
  assign leap     = (rem[1:0] == 2'd0) && ((rem != 7'd0) || (quo[1:0] == 2'd0));
  assign mlen     = cma_pkg::month_len(item_i.load_month, leap);
  assign early    = (item_i.load_month < 4'd3) && (item_i.load_year != 14'd0);

  always_comb begin
    prep_d.opcode  = item_i.opcode;
    prep_d.load_ok = (item_i.load_year >= 14'd1) && (item_i.load_year <= cma_pkg::MAX_YEAR) &&
                     (item_i.load_month >= 4'd1) && (item_i.load_month <= 4'd12) &&
                     (item_i.load_hour <= 5'd23) && (item_i.load_minute <= 6'd59) &&
                     (item_i.load_day >= 5'd1) && (item_i.load_day <= mlen);
    prep_d.year    = item_i.load_year;
    prep_d.cent    = quo[6:0];
    prep_d.yrem    = rem;
    prep_d.month   = item_i.load_month;
    prep_d.day     = item_i.load_day;
    prep_d.hour    = item_i.load_hour;
    prep_d.minute  = item_i.load_minute;
    prep_d.wk_year = early ? item_i.load_year - 14'd1 : item_i.load_year;
    prep_d.wk_cent = (early && (rem == 7'd0)) ? quo - 8'd1 : quo;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prep_q <= prep_d;
    end
  end

  assign prep_o = prep_q;

endmodule

@@ hdl/cma_calendar.sv @@
// Calendar state: loads a checked date or advances one minute, and tracks the weekday.
`timescale 1ns / 1ps

module cma_calendar (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  cma_pkg::prep_t     prep_i,
  output cma_pkg::date_t     now_o,
  output cma_pkg::status_e   status_o
);

  logic [13:0] year_q, year_d;
  logic [6:0]  cent_q, cent_d;
  logic [6:0]  yrem_q, yrem_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  day_q, day_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;
  logic [2:0]  wday_q, wday_d;

  cma_pkg::status_e status;
  logic        leap;
  logic [4:0]  mlen;
  logic        last;
  logic [15:0] wsum;
  logic [5:0]  fold1;
  logic [3:0]  fold2;
  logic [2:0]  fold3;
  logic [2:0]  load_wday;

  assign leap = (yrem_q[1:0] == 2'd0) && ((yrem_q != 7'd0) || (cent_q[1:0] == 2'd0));
  assign mlen = cma_pkg::month_len(month_q, leap);
  assign last = (minute_q >= 6'd59) && (hour_q >= 5'd23) && (month_q >= 4'd12) &&
                (day_q >= mlen) && (year_q >= cma_pkg::MAX_YEAR);

  // Weekday of a loaded date; the remainder by 7 folds octal digits since 8 = 1 mod 7.
  assign wsum  = {2'd0, prep_i.wk_year} + {4'd0, prep_i.wk_year[13:2]} -
                 {8'd0, prep_i.wk_cent} + {10'd0, prep_i.wk_cent[7:2]} +
                 {13'd0, cma_pkg::month_offset(prep_i.month)} + {11'd0, prep_i.day};
  assign fold1 = {3'd0, wsum[2:0]} + {3'd0, wsum[5:3]} + {3'd0, wsum[8:6]} +
                 {3'd0, wsum[11:9]} + {3'd0, wsum[14:12]} + {5'd0, wsum[15]};
  assign fold2 = {1'b0, fold1[2:0]} + {1'b0, fold1[5:3]};
  assign fold3 = fold2[2:0] + {2'd0, fold2[3]};
  assign load_wday = (fold3 == 3'd7) ? 3'd0 : fold3;

  always_comb begin
    year_d   = year_q;
    cent_d   = cent_q;
    yrem_d   = yrem_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    wday_d   = wday_q;
    status   = cma_pkg::ST_OK;
    if (prep_i.opcode == cma_pkg::OP_LOAD) begin
      if (prep_i.load_ok) begin
        year_d   = prep_i.year;
        cent_d   = prep_i.cent;
        yrem_d   = prep_i.yrem;
        month_d  = prep_i.month;
        day_d    = prep_i.day;
        hour_d   = prep_i.hour;
        minute_d = prep_i.minute;
        wday_d   = load_wday;
      end else begin
        status = cma_pkg::ST_BAD_LOAD;
      end
    end else if (last) begin
      status = cma_pkg::ST_OVERFLOW;
    end else if (minute_q < 6'd59) begin
      minute_d = minute_q + 6'd1;
    end else begin
      minute_d = 6'd0;
      if (hour_q < 5'd23) begin
        hour_d = hour_q + 5'd1;
      end else begin
        hour_d = 5'd0;
        wday_d = (wday_q == 3'd6) ? 3'd0 : wday_q + 3'd1;
        if (day_q < mlen) begin
          day_d = day_q + 5'd1;
        end else begin
          day_d = 5'd1;
          if (month_q < 4'd12) begin
            month_d = month_q + 4'd1;
          end else begin
            month_d = 4'd1;
            year_d  = year_q + 14'd1;
            if (yrem_q == 7'd99) begin
              yrem_d = 7'd0;
              cent_d = cent_q + 7'd1;
            end else begin
              yrem_d = yrem_q + 7'd1;
            end
          end
        end
      end
    end
  end

  // Reset date is 1 January of year 1, a Monday.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q   <= 14'd1;
      cent_q   <= 7'd0;
      yrem_q   <= 7'd1;
      month_q  <= 4'd1;
      day_q    <= 5'd1;
      hour_q   <= 5'd0;
      minute_q <= 6'd0;
      wday_q   <= 3'd1;
    end else if (step_i) begin
      year_q   <= year_d;
      cent_q   <= cent_d;
      yrem_q   <= yrem_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      wday_q   <= wday_d;
    end
  end

  always_comb begin
    now_o.year   = year_d;
    now_o.month  = month_d;
    now_o.day    = day_d;
    now_o.hour   = hour_d;
    now_o.minute = minute_d;
    now_o.wday   = wday_d;
  end

  assign status_o = status;

`ifndef SYNTHESIS
  // The split year must always agree with the binary year.
  a_year_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    year_q == ({cent_q, 7'd0} - {2'd0, cent_q, 5'd0} + {5'd0, cent_q, 2'd0} + {7'd0, yrem_q}))
    else $error("cma_calendar: year does not match its hundreds split");

  // A refused load leaves the whole date untouched.
  a_bad_load_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (prep_i.opcode == cma_pkg::OP_LOAD) && !prep_i.load_ok |=>
      $stable(year_q) && $stable(month_q) && $stable(day_q) &&
      $stable(hour_q) && $stable(minute_q) && $stable(wday_q))
    else $error("cma_calendar: refused load changed the date");

  // On an advance, the weekday moves only when the day rolls over.
  a_wday_roll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (prep_i.opcode == cma_pkg::OP_ADVANCE) && (hour_q != 5'd23) |=> $stable(wday_q))
    else $error("cma_calendar: weekday changed within a day");
`endif

endmodule

@@ hdl/cma_match.sv @@
// Cron match of one calendar time against the five field masks.
`timescale 1ns / 1ps

module cma_match (
  input  cma_pkg::cfg_t   cfg_i,
  input  cma_pkg::date_t  now_i,
  output logic            alarm_o
);

  logic [4:0] day_idx;
  logic [3:0] month_idx;
  logic       dom;
  logic       dwm;
  logic       day_ok;

  assign day_idx   = now_i.day - 5'd1;
  assign month_idx = now_i.month - 4'd1;
  assign dom       = cfg_i.day_mask[day_idx];
  // Sunday matches on bit 0 and on bit 7.
  assign dwm       = cfg_i.weekday_mask[now_i.wday] ||
                     ((now_i.wday == 3'd0) && cfg_i.weekday_mask[7]);

  // When both day fields are restricted, either one may match.
  always_comb begin
    if (!cfg_i.day_wild && !cfg_i.weekday_wild) begin
      day_ok = dom || dwm;
    end else if (!cfg_i.day_wild) begin
      day_ok = dom;
    end else if (!cfg_i.weekday_wild) begin
      day_ok = dwm;
    end else begin
      day_ok = 1'b1;
    end
  end

  assign alarm_o = cfg_i.minute_mask[now_i.minute] && cfg_i.hour_mask[now_i.hour] &&
                   cfg_i.month_mask[month_idx] && day_ok;

endmodule

@@ tb/sv/cma_calendar_check.sv @@
// Checker for the cron minute alarm: predicts each result from the accepted items and compares.
`timescale 1ns / 1ps

module cma_calendar_check
  import cma_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  cma_item_if   in_ch,
  cma_result_if res_ch,
  cma_cfg_if    cfg_ch,
  output int    fail_count_o,
  output int    pending_o
);

  // Predicted calendar and the register file as the block should hold them.
  logic [13:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  cfg_t        cfg_q;

  result_t     expected_times[$];
  int          mismatches;

  function automatic bit is_leap(int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int month_span(int y, int m);
    case (m) inside
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic int month_shift(int m);
    case (m) inside
      2, 6:    return 3;
      3, 11:   return 2;
      4, 7:    return 5;
      8:       return 1;
      9, 12:   return 4;
      10:      return 6;
      default: return 0;
    endcase
  endfunction

  // Month-offset weekday rule; January and February count with the previous year.
  function automatic logic [2:0] weekday_of(int y, int m, int d);
    int yy;
    yy = y;
    if (m < 3 && yy > 0) yy--;
    return 3'((yy + yy / 4 - yy / 100 + yy / 400 + month_shift(m) + d) % 7);
  endfunction

  function automatic logic alarm_at(logic [2:0] wd);
    logic by_day;
    logic by_wday;
    if (!cfg_q.minute_mask[minute_q] || !cfg_q.hour_mask[hour_q] ||
        !cfg_q.month_mask[month_q - 4'd1]) return 1'b0;
    by_day  = cfg_q.day_mask[day_q - 5'd1];
    by_wday = cfg_q.weekday_mask[wd] || (wd == 3'd0 && cfg_q.weekday_mask[7]);
    // With both day fields restricted, either one is enough.
    if (!cfg_q.day_wild && !cfg_q.weekday_wild) return by_day || by_wday;
    if (!cfg_q.day_wild) return by_day;
    if (!cfg_q.weekday_wild) return by_wday;
    return 1'b1;
  endfunction

  // Applies one item to the predicted calendar and returns the result it should produce.
  function automatic result_t step_calendar(item_t it);
    result_t r;
    status_e st;
    int      dim;
    logic [2:0] wd;
    st = ST_OK;
    if (it.opcode == OP_LOAD) begin
      if (it.load_year < 14'd1 || it.load_year > MAX_YEAR || it.load_month < 4'd1 ||
          it.load_month > 4'd12 || it.load_hour > 5'd23 || it.load_minute > 6'd59 ||
          it.load_day < 5'd1 ||
          int'(it.load_day) > month_span(int'(it.load_year), int'(it.load_month))) begin
        st = ST_BAD_LOAD;
      end else begin
        year_q   = it.load_year;
        month_q  = it.load_month;
        day_q    = it.load_day;
        hour_q   = it.load_hour;
        minute_q = it.load_minute;
      end
    end else begin
      dim = month_span(int'(year_q), int'(month_q));
      if (minute_q >= 6'd59 && hour_q >= 5'd23 && month_q >= 4'd12 && int'(day_q) >= dim &&
          year_q >= MAX_YEAR) begin
        st = ST_OVERFLOW;
      end else if (minute_q < 6'd59) begin
        minute_q++;
      end else begin
        minute_q = '0;
        if (hour_q < 5'd23) begin
          hour_q++;
        end else begin
          hour_q = '0;
          if (int'(day_q) < dim) begin
            day_q++;
          end else begin
            day_q = 5'd1;
            if (month_q < 4'd12) begin
              month_q++;
            end else begin
              month_q = 4'd1;
              year_q++;
            end
          end
        end
      end
    end
    wd = weekday_of(int'(year_q), int'(month_q), int'(day_q));
    r.cur_year   = year_q;
    r.cur_month  = month_q;
    r.cur_day    = day_q;
    r.cur_hour   = hour_q;
    r.cur_minute = minute_q;
    r.weekday    = wd;
    r.alarm      = alarm_at(wd);
    r.status     = st;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    mismatches++;
  endtask

  task automatic check_result(result_t want, result_t got);
    if (got.cur_year !== want.cur_year) report_mismatch("year", want.cur_year, got.cur_year);
    if (got.cur_month !== want.cur_month)
      report_mismatch("month", want.cur_month, got.cur_month);
    if (got.cur_day !== want.cur_day) report_mismatch("day", want.cur_day, got.cur_day);
    if (got.cur_hour !== want.cur_hour) report_mismatch("hour", want.cur_hour, got.cur_hour);
    if (got.cur_minute !== want.cur_minute)
      report_mismatch("minute", want.cur_minute, got.cur_minute);
    if (got.weekday !== want.weekday) report_mismatch("weekday", want.weekday, got.weekday);
    if (got.alarm !== want.alarm) report_mismatch("alarm", want.alarm, got.alarm);
    if (got.status !== want.status) report_mismatch("status", want.status, got.status);
  endtask

  // Order within an edge: register writes, then the result leaving, then the item entering,
  // since a result accepted now always belongs to an item taken earlier.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q   = 14'd1;
      month_q  = 4'd1;
      day_q    = 5'd1;
      hour_q   = '0;
      minute_q = '0;
      cfg_q              = '0;
      cfg_q.day_wild     = 1'b1;
      cfg_q.weekday_wild = 1'b1;
      expected_times.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          CFG_MINUTE_MASK:  cfg_q.minute_mask  = cfg_ch.wdata;
          CFG_HOUR_MASK:    cfg_q.hour_mask    = cfg_ch.wdata[23:0];
          CFG_DAY_MASK:     cfg_q.day_mask     = cfg_ch.wdata[30:0];
          CFG_MONTH_MASK:   cfg_q.month_mask   = cfg_ch.wdata[11:0];
          CFG_WEEKDAY_MASK: cfg_q.weekday_mask = cfg_ch.wdata[7:0];
          CFG_DAY_WILD:     cfg_q.day_wild     = cfg_ch.wdata[0];
          CFG_WEEKDAY_WILD: cfg_q.weekday_wild = cfg_ch.wdata[0];
          default: ;
        endcase
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_times.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got year %0d minute %0d",
                   $time, res_ch.payload.cur_year, res_ch.payload.cur_minute);
          mismatches++;
        end else begin
          check_result(expected_times.pop_front(), res_ch.payload);
        end
      end
      if (in_ch.valid && in_ch.ready) expected_times.push_back(step_calendar(in_ch.payload));
      pending_o    <= expected_times.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

@@ tb/sv/tb_cron_minute_alarm.sv @@
// Top of the cron minute alarm testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_cron_minute_alarm;
  import cma_pkg::*;

  // The register index just past the last real register; the block must ignore it.
  localparam logic [2:0]  CFG_UNUSED  = 3'd7;
  localparam logic [59:0] ALL_ONES    = '1;
  localparam int          HOLD_CYCLES = 400;
  localparam int          QUIET_LIMIT = 5000;
  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cma_item_if   in_ch ();
  cma_result_if res_ch ();
  cma_cfg_if    cfg_ch ();

  int fail_count;
  int pending;

  // Percentages of cycles in which the sender idles and the receiver stalls. The sender's
  // figure is only read by the stimulus process; the receiver's is changed at clock edges.
  int send_idle_pct = 0;
  int stall_pct = 0;

  // Each increment asks the receiver for one long hold-off.
  int hold_seq = 0;
  int hold_seen;
  int hold_left;
  int quiet_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cron_minute_alarm i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_ch),
    .res_ch (res_ch),
    .cfg_ch (cfg_ch)
  );

  cma_calendar_check i_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_ch        (in_ch),
    .res_ch       (res_ch),
    .cfg_ch       (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Result receiver. A requested hold-off keeps ready low until a countdown from HOLD_CYCLES
  // has run out, otherwise ready drops at random as the current stall percentage says.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      hold_seen    <= 0;
      hold_left    <= 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen    <= hold_seq;
      hold_left    <= HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: a run that moves nothing across any channel for too long has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("cron_minute_alarm regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [59:0] rand60();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[59:0];
  endfunction

  // Masks with about three bits in four set, so that alarms are common.
  function automatic logic [59:0] dense();
    return rand60() | rand60();
  endfunction

  // An advance item; its load fields are ignored by the block, so they carry noise.
  function automatic item_t tick_item();
    item_t it;
    it.opcode      = OP_ADVANCE;
    it.load_year   = 14'($urandom_range(16383));
    it.load_month  = 4'($urandom_range(15));
    it.load_day    = 5'($urandom_range(31));
    it.load_hour   = 5'($urandom_range(31));
    it.load_minute = 6'($urandom_range(63));
    return it;
  endfunction

  // Any value of every field, load or advance.
  function automatic item_t noise_item();
    item_t it;
    it        = tick_item();
    it.opcode = $urandom_range(1) ? OP_ADVANCE : OP_LOAD;
    return it;
  endfunction

  // A load aimed at the interesting corners: year ends, month ends, the last minutes of the
  // day, leap and century years. A day past the month's end now and then gets refused.
  function automatic item_t sensible_load();
    item_t it;
    it.opcode = OP_LOAD;
    case ($urandom_range(5))
      0:       it.load_year = MAX_YEAR;
      1:       it.load_year = 14'($urandom_range(99, 1) * 100);
      2:       it.load_year = 14'($urandom_range(2499, 1) * 4);
      3:       it.load_year = 14'($urandom_range(9999, 1));
      4:       it.load_year = 14'($urandom_range(3, 1));
      default: it.load_year = 14'($urandom_range(9999, 9990));
    endcase
    if ($urandom_range(1)) it.load_month = 4'($urandom_range(12, 1));
    else it.load_month = $urandom_range(1) ? 4'd12 : 4'd2;
    it.load_day    = $urandom_range(1) ? 5'($urandom_range(28, 1)) : 5'($urandom_range(31, 28));
    it.load_hour   = $urandom_range(1) ? 5'($urandom_range(23)) : 5'd23;
    it.load_minute = $urandom_range(1) ? 6'($urandom_range(59)) : 6'($urandom_range(59, 55));
    return it;
  endfunction

  // Offers one item, after a random idle gap, and returns once it has been taken. Valid
  // stays high from one item to the next unless an idle cycle falls in between.
  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_load(int y, int m, int d, int h, int mi);
    item_t it;
    it.opcode      = OP_LOAD;
    it.load_year   = 14'(y);
    it.load_month  = 4'(m);
    it.load_day    = 5'(d);
    it.load_hour   = 5'(h);
    it.load_minute = 6'(mi);
    send_item(it);
  endtask

  // Stops offering items and waits until every predicted result has been seen. The first
  // edge lets the checker count the item taken at the edge this task was called on.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes one register; valid is left high so that writes can follow back to back.
  task automatic write_reg(logic [2:0] idx, logic [59:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.wdata <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Rewrites the whole register file, plus a write to the unused index that must change
  // nothing. Full 60-bit data goes to every register, so bits above a mask's width are
  // exercised too.
  task automatic configure(logic [59:0] minute_m, logic [59:0] hour_m, logic [59:0] day_m,
                           logic [59:0] month_m, logic [59:0] weekday_m,
                           logic day_wild, logic weekday_wild);
    write_reg(CFG_UNUSED, rand60());
    write_reg(CFG_MINUTE_MASK, minute_m);
    write_reg(CFG_HOUR_MASK, hour_m);
    write_reg(CFG_DAY_MASK, day_m);
    write_reg(CFG_MONTH_MASK, month_m);
    write_reg(CFG_WEEKDAY_MASK, weekday_m);
    write_reg(CFG_DAY_WILD, {rand60() & ~60'd1} | 60'(day_wild));
    write_reg(CFG_WEEKDAY_WILD, {rand60() & ~60'd1} | 60'(weekday_wild));
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly well-formed traffic: a load near some boundary followed by a run of advances,
  // usually short, sometimes long enough to roll the hour. One pick in ten is a single noise item.
  task automatic run_traffic(int count);
    int left;
    int run;
    left = count;
    while (left > 0) begin
      if ($urandom_range(9) == 0) begin
        send_item(noise_item());
        left--;
      end else begin
        send_item(sensible_load());
        left--;
        run = ($urandom_range(7) == 0) ? $urandom_range(70, 1) : $urandom_range(6, 1);
        while (run > 0 && left > 0) begin
          send_item(tick_item());
          run--;
          left--;
        end
      end
    end
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.addr   = '0;
    cfg_ch.wdata  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items, under the reset register values (no minute matches, so no alarm).
    // An advance straight out of reset, then the earliest valid load.
    send_item(tick_item());
    send_load(1, 1, 1, 0, 0);
    // Refused loads: year zero, every field at its all-ones value, month zero and past
    // December, day zero, a day past a 30-day month, February 29 in a century that is not
    // a leap year and in a plain common year, hour 24 and minute 60.
    send_load(0, 6, 15, 12, 30);
    send_load(16383, 15, 31, 31, 63);
    send_load(2024, 0, 10, 10, 10);
    send_load(2024, 13, 10, 10, 10);
    send_load(2024, 5, 0, 10, 10);
    send_load(2023, 4, 31, 10, 10);
    send_load(1900, 2, 29, 10, 10);
    send_load(2023, 2, 29, 10, 10);
    // February 29 of a year divisible by 400 is fine.
    send_load(2000, 2, 29, 12, 30);
    send_load(2024, 3, 3, 24, 0);
    send_load(2024, 3, 3, 0, 60);
    // Midnight rollovers into a leap day, out of a leap day and into a new year.
    send_load(2024, 2, 28, 23, 59);
    send_item(tick_item());
    send_load(2024, 2, 29, 23, 59);
    send_item(tick_item());
    send_load(2023, 12, 31, 23, 59);
    send_item(tick_item());
    // The last minute but one, one advance onto the last, then two that must hold the time.
    send_load(9999, 12, 31, 23, 58);
    send_item(tick_item());
    send_item(tick_item());
    send_item(tick_item());

    // Random phases. Each one starts from an idle block, rewrites the registers and picks
    // an idling pattern: none, a slow sender, a slow receiver, or a little of both.
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: configure(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, 1'b1);
        1: configure('0, '0, '0, '0, '0, 1'b0, 1'b0);
        2: configure(dense(), dense(), dense(), dense(), rand60(), 1'b0, 1'b0);
        3: configure(dense(), dense(), rand60(), dense(), rand60(), 1'b0, 1'b1);
        // Sunday only through the extra weekday bit.
        4: configure(ALL_ONES, ALL_ONES, rand60(), ALL_ONES, 60'h80, 1'b1, 1'b0);
        5: configure(ALL_ONES, ALL_ONES, '0, ALL_ONES, 60'h80, 1'b0, 1'b0);
        6: configure(rand60(), rand60(), rand60(), rand60(), rand60(),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
        default: configure(dense(), ALL_ONES, ALL_ONES, dense(), '0, 1'b0, 1'b1);
      endcase
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 77;
          stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct <= 77;
        end
        default: begin
          send_idle_pct = 12;
          stall_pct <= 12;
        end
      endcase
      // In the phases without idling, the receiver first holds off for a long stretch while
      // items keep coming, so the block fills and pushes back; then the sender waits until
      // every result is out before the normal traffic resumes.
      if (p % 4 == 0) begin
        hold_seq <= hold_seq + 1;
        run_traffic(40);
        wait_idle();
      end
      run_traffic(PHASE_ITEMS);
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("cron_minute_alarm regression: pass");
    end else begin
      $display("cron_minute_alarm regression: fail");
    end
    $finish;
  end

endmodule
